>>> rtl/core/mrim_pkg.sv
`default_nettype none

package mrim_pkg;

	localparam int MAX_REGISTERS = 125;

	// input item kinds
	localparam logic [1:0] KIND_START   = 2'd0;
	localparam logic [1:0] KIND_BYTE    = 2'd1;
	localparam logic [1:0] KIND_TIMEOUT = 2'd2;

	// result item kinds
	localparam logic [1:0] OUT_TX     = 2'd0;
	localparam logic [1:0] OUT_DATA   = 2'd1;
	localparam logic [1:0] OUT_STATUS = 2'd2;

	// exchange status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// queued commands from front to back
	localparam logic [1:0] CMD_REQ  = 2'd0;
	localparam logic [1:0] CMD_DATA = 2'd1;
	localparam logic [1:0] CMD_STAT = 2'd2;

	localparam logic [7:0]  FUNC_CODE = 8'h04;
	localparam logic [7:0]  QTY_HIGH  = 8'h00;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// response layout: id, function, byte count, data, two CRC bytes
	localparam logic [8:0] RSP_IDX_ID    = 9'd0;
	localparam logic [8:0] RSP_IDX_FUNC  = 9'd1;
	localparam logic [8:0] RSP_IDX_COUNT = 9'd2;
	localparam logic [8:0] RSP_HDR_BYTES = 9'd3;
	localparam logic [8:0] RSP_CRC_BYTES = 9'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  dev_id;
		logic [15:0] addr;
		logic [6:0]  count;
		logic [7:0]  data;
		logic [1:0]  status;
	} cmd_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/mrim_in_if.sv
`default_nettype none

interface mrim_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] reg_addr;
	logic [6:0]  reg_count;
	logic [7:0]  rx_byte;

	modport source (output valid, kind, reg_addr, reg_count, rx_byte, input ready);
	modport sink (input valid, kind, reg_addr, reg_count, rx_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mrim_out_if.sv
`default_nettype none

interface mrim_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] byte_value;
	logic [1:0] status;
	logic       last;

	modport source (output valid, out_kind, byte_value, status, last, input ready);
	modport sink (input valid, out_kind, byte_value, status, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/mrim_front.sv
`default_nettype none

module mrim_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [7:0]    cfg_wdata,
	mrim_in_if.sink       in_ch,
	output logic          push_valid,
	input  logic          push_ready,
	output mrim_pkg::cmd_t push_cmd
);
	import mrim_pkg::*;

	logic [7:0] device_id_q;
	logic       awaiting_q;
	logic [6:0] expected_q;
	logic [8:0] rcvd_q;
	logic       bad_q;

	logic       awaiting_d;
	logic [6:0] expected_d;
	logic [8:0] rcvd_d;
	logic       bad_d;

	logic       accept;
	logic [6:0] n_sat;
	logic [8:0] nbytes;
	logic [8:0] data_end;
	logic [8:0] frame_end;

	assign in_ch.ready = push_ready;
	assign accept      = in_ch.valid & push_ready;
	assign n_sat       = (in_ch.reg_count > 7'(MAX_REGISTERS)) ? 7'(MAX_REGISTERS)
	                                                           : in_ch.reg_count;
	assign nbytes      = {1'b0, expected_q, 1'b0};
	assign data_end    = RSP_HDR_BYTES + nbytes;
	assign frame_end   = data_end + RSP_CRC_BYTES - 9'd1;

	always_comb begin
		push_valid = 1'b0;
		push_cmd   = '0;
		awaiting_d = awaiting_q;
		expected_d = expected_q;
		rcvd_d     = rcvd_q;
		bad_d      = bad_q;
		if (accept) begin
			case (in_ch.kind)
				KIND_START: begin
					push_valid      = 1'b1;
					push_cmd.op     = CMD_REQ;
					push_cmd.dev_id = device_id_q;
					push_cmd.addr   = in_ch.reg_addr;
					push_cmd.count  = n_sat;
					awaiting_d      = 1'b1;
					expected_d      = n_sat;
					rcvd_d          = '0;
					bad_d           = 1'b0;
				end
				KIND_BYTE: begin
					if (awaiting_q) begin
						if (rcvd_q == RSP_IDX_ID) begin
							if (in_ch.rx_byte != device_id_q) bad_d = 1'b1;
						end else if (rcvd_q == RSP_IDX_FUNC) begin
							if (in_ch.rx_byte != FUNC_CODE) bad_d = 1'b1;
						end else if (rcvd_q == RSP_IDX_COUNT) begin
							if ({1'b0, in_ch.rx_byte} != nbytes) bad_d = 1'b1;
						end else if (rcvd_q < data_end && !bad_q) begin
							push_valid    = 1'b1;
							push_cmd.op   = CMD_DATA;
							push_cmd.data = in_ch.rx_byte;
						end
						rcvd_d = rcvd_q + 9'd1;
						// last CRC byte closes the frame
						if (rcvd_q >= frame_end) begin
							push_valid      = 1'b1;
							push_cmd.op     = CMD_STAT;
							push_cmd.status = bad_q ? ST_INVALID : ST_OK;
							awaiting_d      = 1'b0;
							rcvd_d          = '0;
							bad_d           = 1'b0;
						end
					end
				end
				KIND_TIMEOUT: begin
					if (awaiting_q) begin
						push_valid      = 1'b1;
						push_cmd.op     = CMD_STAT;
						push_cmd.status = (rcvd_q == '0) ? ST_TIMEOUT : ST_INVALID;
						awaiting_d      = 1'b0;
						rcvd_d          = '0;
						bad_d           = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= 8'd1;
			awaiting_q  <= 1'b0;
			expected_q  <= '0;
			rcvd_q      <= '0;
			bad_q       <= 1'b0;
		end else begin
			if (cfg_we) device_id_q <= cfg_wdata;
			awaiting_q <= awaiting_d;
			expected_q <= expected_d;
			rcvd_q     <= rcvd_d;
			bad_q      <= bad_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mrim_queue.sv
`default_nettype none

module mrim_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  mrim_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output mrim_pkg::cmd_t pop_cmd
);
	import mrim_pkg::*;

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   do_push;
	logic                   do_pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;

	function automatic logic [QUEUE_PTR_W-1:0] ptr_next(input logic [QUEUE_PTR_W-1:0] p);
		return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (do_pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/mrim_back.sv
`default_nettype none

module mrim_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  mrim_pkg::cmd_t pop_cmd,
	mrim_out_if.source     out_ch
);
	import mrim_pkg::*;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  byte_value_q;
	logic [1:0]  status_q;
	logic        last_q;

	logic        busy_q;
	logic [2:0]  step_q;
	logic [15:0] crc_q;
	logic [15:0] addr_q;
	logic [6:0]  count_q;

	logic        load_en;
	logic [7:0]  req_byte;

	assign out_ch.valid      = out_valid_q;
	assign out_ch.out_kind   = out_kind_q;
	assign out_ch.byte_value = byte_value_q;
	assign out_ch.status     = status_q;
	assign out_ch.last       = last_q;

	assign load_en   = !out_valid_q | out_ch.ready;
	assign pop_ready = load_en & !busy_q;

	// request bytes after the device id; CRC bytes go low then high
	always_comb begin
		case (step_q)
			3'd1:    req_byte = FUNC_CODE;
			3'd2:    req_byte = addr_q[15:8];
			3'd3:    req_byte = addr_q[7:0];
			3'd4:    req_byte = QTY_HIGH;
			3'd5:    req_byte = {1'b0, count_q};
			3'd6:    req_byte = crc_q[7:0];
			3'd7:    req_byte = crc_q[15:8];
			default: req_byte = QTY_HIGH;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_kind_q   <= OUT_TX;
			byte_value_q <= '0;
			status_q     <= ST_OK;
			last_q       <= 1'b0;
			busy_q       <= 1'b0;
			step_q       <= '0;
			crc_q        <= CRC_INIT;
			addr_q       <= '0;
			count_q      <= '0;
		end else if (load_en) begin
			if (busy_q) begin
				out_valid_q  <= 1'b1;
				out_kind_q   <= OUT_TX;
				byte_value_q <= req_byte;
				status_q     <= ST_OK;
				last_q       <= (step_q == 3'd7);
				if (step_q < 3'd6) crc_q <= crc_byte(crc_q, req_byte);
				step_q <= step_q + 3'd1;
				if (step_q == 3'd7) busy_q <= 1'b0;
			end else if (pop_valid) begin
				out_valid_q <= 1'b1;
				status_q    <= ST_OK;
				last_q      <= 1'b0;
				case (pop_cmd.op)
					CMD_REQ: begin
						out_kind_q   <= OUT_TX;
						byte_value_q <= pop_cmd.dev_id;
						crc_q        <= crc_byte(CRC_INIT, pop_cmd.dev_id);
						addr_q       <= pop_cmd.addr;
						count_q      <= pop_cmd.count;
						step_q       <= 3'd1;
						busy_q       <= 1'b1;
					end
					CMD_DATA: begin
						out_kind_q   <= OUT_DATA;
						byte_value_q <= pop_cmd.data;
					end
					default: begin
						out_kind_q   <= OUT_STATUS;
						byte_value_q <= '0;
						status_q     <= pop_cmd.status;
						last_q       <= 1'b1;
					end
				endcase
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/modbus_rtu_input_register_master.sv
// channel   side   handshake        beat
// in_ch     sink   valid / ready    kind, reg_addr, reg_count, rx_byte
// out_ch    source valid / ready    out_kind, byte_value, status, last
// cfg       write  cfg_we           cfg_wdata -> device_id
//
// Received bytes and timeouts flow at one beat per cycle while the queue has room.
// A start item leaves as eight request beats, one byte step per cycle in the back
// sequencer while out_ch.ready holds; a two-entry command queue sits between.
// First result is registered in the command queue, then in the back output register.
// in_ch.ready drops while the queue is full; out_ch.ready low backs up into it.
// Reset leaves the master idle with device_id 1; no clearing pass.
`default_nettype none

module modbus_rtu_input_register_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	mrim_in_if.sink    in_ch,
	mrim_out_if.source out_ch
);
	import mrim_pkg::*;

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	mrim_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	mrim_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	mrim_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.out_ch    (out_ch)
	);

endmodule

`default_nettype wire

>>> tb/mrim_reply_checker.sv
`timescale 1ns / 100ps

module mrim_reply_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	mrim_in_if         in_mon,
	mrim_out_if        out_mon,
	output int         mismatches,
	output int         pending
);
	import mrim_pkg::*;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] byte_value;
		logic [1:0] status;
		logic       last;
	} reply_beat_t;

	reply_beat_t reply_q[$];

	// mirror of the master's exchange state
	logic [7:0] dev_id      = 8'd1;
	logic       waiting     = 1'b0;
	logic [6:0] regs_wanted = 7'd0;
	logic [8:0] rx_seen     = 9'd0;
	logic       hdr_bad     = 1'b0;

	int bad_beats = 0;
	int queued    = 0;

	assign mismatches = bad_beats;
	assign pending    = queued;

	// bit-serial CRC-16, reflected polynomial, LSB of the data byte first
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		logic        fb;
		int          i;
		acc = crc;
		for (i = 0; i < 8; i++) begin
			fb  = acc[0] ^ b[i];
			acc = {1'b0, acc[15:1]};
			if (fb)
				acc = acc ^ CRC_POLY;
		end
		return acc;
	endfunction

	task automatic queue_reply(input logic [1:0] k, input logic [7:0] v, input logic [1:0] s,
			input logic l);
		reply_beat_t e;
		e.out_kind   = k;
		e.byte_value = v;
		e.status     = s;
		e.last       = l;
		reply_q.push_back(e);
	endtask

	task automatic predict_replies(input logic [1:0] k, input logic [15:0] addr,
			input logic [6:0] n, input logic [7:0] b);
		logic [7:0]  req [8];
		logic [15:0] crc;
		logic [6:0]  q;
		logic [8:0]  nbytes;
		logic [8:0]  total;
		int          i;
		case (k)
			KIND_START: begin
				q = (n > MAX_REGISTERS) ? 7'(MAX_REGISTERS) : n;
				req[0] = dev_id;
				req[1] = FUNC_CODE;
				req[2] = addr[15:8];
				req[3] = addr[7:0];
				req[4] = QTY_HIGH;
				req[5] = {1'b0, q};
				crc = CRC_INIT;
				for (i = 0; i < 6; i++)
					crc = crc16_fold(crc, req[i]);
				req[6] = crc[7:0];
				req[7] = crc[15:8];
				for (i = 0; i < 8; i++)
					queue_reply(OUT_TX, req[i], ST_OK, i == 7);
				// a start drops any pending exchange silently
				waiting     = 1'b1;
				regs_wanted = q;
				rx_seen     = 9'd0;
				hdr_bad     = 1'b0;
			end
			KIND_BYTE: begin
				if (waiting) begin
					nbytes = {1'b0, regs_wanted, 1'b0};
					total  = nbytes + RSP_HDR_BYTES + RSP_CRC_BYTES;
					if (rx_seen == RSP_IDX_ID) begin
						if (b != dev_id)
							hdr_bad = 1'b1;
					end else if (rx_seen == RSP_IDX_FUNC) begin
						if (b != FUNC_CODE)
							hdr_bad = 1'b1;
					end else if (rx_seen == RSP_IDX_COUNT) begin
						if ({1'b0, b} != nbytes)
							hdr_bad = 1'b1;
					end else if (rx_seen < RSP_HDR_BYTES + nbytes) begin
						if (!hdr_bad)
							queue_reply(OUT_DATA, b, ST_OK, 1'b0);
					end
					if (rx_seen + 9'd1 >= total) begin
						queue_reply(OUT_STATUS, 8'd0, hdr_bad ? ST_INVALID : ST_OK, 1'b1);
						waiting = 1'b0;
						rx_seen = 9'd0;
						hdr_bad = 1'b0;
					end else begin
						rx_seen = rx_seen + 9'd1;
					end
				end
			end
			KIND_TIMEOUT: begin
				if (waiting) begin
					queue_reply(OUT_STATUS, 8'd0, (rx_seen == 9'd0) ? ST_TIMEOUT : ST_INVALID,
						1'b1);
					waiting = 1'b0;
					rx_seen = 9'd0;
					hdr_bad = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	task automatic note_bad(input string why, input reply_beat_t got, input reply_beat_t want);
		bad_beats++;
		if (bad_beats <= 10)
			$display({"%0t %s: got kind=%0d byte=%02h status=%0d last=%0b,",
				" expected kind=%0d byte=%02h status=%0d last=%0b"},
				$time, why, got.out_kind, got.byte_value, got.status, got.last,
				want.out_kind, want.byte_value, want.status, want.last);
	endtask

	// sample on the falling edge ahead of the rising edge that takes the beat
	always @(negedge clk) begin
		reply_beat_t seen;
		reply_beat_t want;
		if (!arst_n) begin
			dev_id      = 8'd1;
			waiting     = 1'b0;
			regs_wanted = 7'd0;
			rx_seen     = 9'd0;
			hdr_bad     = 1'b0;
			reply_q.delete();
		end else begin
			if (cfg_we)
				dev_id = cfg_wdata;
			if (in_mon.valid && in_mon.ready)
				predict_replies(in_mon.kind, in_mon.reg_addr, in_mon.reg_count,
					in_mon.rx_byte);
			if (out_mon.valid && out_mon.ready) begin
				seen.out_kind   = out_mon.out_kind;
				seen.byte_value = out_mon.byte_value;
				seen.status     = out_mon.status;
				seen.last       = out_mon.last;
				if (reply_q.size() == 0) begin
					note_bad("beat with nothing pending", seen, '0);
				end else begin
					want = reply_q.pop_front();
					if (seen !== want)
						note_bad("beat mismatch", seen, want);
				end
			end
		end
		queued = reply_q.size();
	end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import mrim_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int NO_FAULT      = -1;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 150;
	localparam int PHASE_ITEMS   = 70;

	typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_CADENCE} rx_pace_t;
	typedef enum {SHAPE_GOOD, SHAPE_NOISY, SHAPE_BAD_HEADER, SHAPE_SHORT, SHAPE_SILENT,
		SHAPE_ABANDON} reply_shape_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	int         mismatches;
	int         pending;

	mrim_in_if  in_ch();
	mrim_out_if out_ch();

	modbus_rtu_input_register_master dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	mrim_reply_checker reply_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_mon     (in_ch),
		.out_mon    (out_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	logic [7:0] cur_id      = 8'd1;
	int         burst_left  = 0;
	bit         flood       = 1'b0;
	int         items_sent  = 0;
	int         holds_asked = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: picks a new random pace when its span runs out, honors hold requests
	initial begin
		rx_pace_t pace;
		int       span;
		int       holds_done;
		out_ch.ready <= 1'b0;
		pace       = RX_FREE;
		span       = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (span == 0) begin
				pace = rx_pace_t'($urandom_range(0, 3));
				span = $urandom_range(16, 96);
			end
			span--;
			case (pace)
				RX_FREE:   out_ch.ready <= 1'b1;
				RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default:   out_ch.ready <= (span % 3 != 0);
			endcase
		end
	end

	task automatic put_beat(input logic [1:0] k, input logic [15:0] a, input logic [6:0] n,
			input logic [7:0] b);
		bit took;
		int gap;
		if (burst_left == 0 && !flood) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_ch.valid     <= 1'b1;
		in_ch.kind      <= k;
		in_ch.reg_addr  <= a;
		in_ch.reg_count <= n;
		in_ch.rx_byte   <= b;
		do begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end while (!took);
		if (burst_left > 0)
			burst_left--;
		items_sent++;
	endtask

	// send the first 'upto' bytes of a response frame for q registers
	task automatic put_reply(input logic [6:0] q, input int fault, input int upto, input bit noisy);
		logic [7:0] b;
		int         i;
		for (i = 0; i < upto; i++) begin
			if (i == RSP_IDX_ID)
				b = cur_id;
			else if (i == RSP_IDX_FUNC)
				b = FUNC_CODE;
			else if (i == RSP_IDX_COUNT)
				b = {q, 1'b0};
			else
				b = 8'($urandom);
			if (i == fault)
				b = b ^ 8'($urandom_range(1, 255));
			if (noisy && $urandom_range(0, 5) == 0)
				put_beat(KIND_UNUSED, 16'($urandom), 7'($urandom), 8'($urandom));
			put_beat(KIND_BYTE, 16'($urandom), 7'($urandom), b);
		end
	endtask

	task automatic run_exchange();
		logic [6:0]   n;
		logic [6:0]   q;
		int           roll;
		int           total;
		reply_shape_t shape;
		roll = $urandom_range(0, 39);
		if (roll == 0)
			n = 7'($urandom_range(120, 127));
		else if (roll < 6)
			n = 7'($urandom_range(5, 24));
		else
			n = 7'($urandom_range(0, 4));
		q = (n > MAX_REGISTERS) ? 7'(MAX_REGISTERS) : n;
		total = 5 + 2 * q;
		roll = $urandom_range(0, 19);
		shape = roll < 10 ? SHAPE_GOOD : roll < 12 ? SHAPE_NOISY :
			roll < 14 ? SHAPE_BAD_HEADER : roll < 17 ? SHAPE_SHORT :
			roll < 18 ? SHAPE_SILENT : SHAPE_ABANDON;
		put_beat(KIND_START, 16'($urandom), n, 8'($urandom));
		case (shape)
			SHAPE_GOOD:       put_reply(q, NO_FAULT, total, 1'b0);
			SHAPE_NOISY:      put_reply(q, NO_FAULT, total, 1'b1);
			SHAPE_BAD_HEADER: put_reply(q, $urandom_range(0, 2), total, 1'b0);
			SHAPE_SHORT: begin
				put_reply(q, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : NO_FAULT,
					$urandom_range(1, total - 1), 1'b0);
				put_beat(KIND_TIMEOUT, 16'($urandom), 7'($urandom), 8'($urandom));
			end
			SHAPE_SILENT:     put_beat(KIND_TIMEOUT, 16'($urandom), 7'($urandom), 8'($urandom));
			// leave it hanging; a later timeout or the next start ends it
			default:          put_reply(q, NO_FAULT, $urandom_range(0, 3), 1'b0);
		endcase
		if ($urandom_range(0, 7) == 0) begin
			roll = $urandom_range(0, 2);
			put_beat(roll == 0 ? KIND_BYTE : roll == 1 ? KIND_TIMEOUT : KIND_UNUSED,
				16'($urandom), 7'($urandom), 8'($urandom));
		end
	endtask

	// drop valid and wait out every pending result, plus the tail of ignored beats
	task automatic drain();
		in_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_device_id(input logic [7:0] id);
		cfg_we    <= 1'b1;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_id = id;
	endtask

	initial begin
		int target;
		int ph;
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_wdata       <= 8'd0;
		in_ch.valid     <= 1'b0;
		in_ch.kind      <= KIND_START;
		in_ch.reg_addr  <= 16'd0;
		in_ch.reg_count <= 7'd0;
		in_ch.rx_byte   <= 8'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame, answered in full
		put_beat(KIND_START, 16'h0000, 7'd0, 8'h00);
		put_reply(7'd0, NO_FAULT, 5, 1'b0);
		// count above the limit saturates; timeout with no bytes
		put_beat(KIND_START, 16'hFFFF, 7'd127, 8'hFF);
		put_beat(KIND_TIMEOUT, 16'h0000, 7'd0, 8'h00);
		// idle: bytes, timeouts and the unused kind are dropped
		put_beat(KIND_BYTE, 16'hFFFF, 7'h7F, 8'hA5);
		put_beat(KIND_TIMEOUT, 16'hFFFF, 7'h7F, 8'hFF);
		put_beat(KIND_UNUSED, 16'h5555, 7'h2A, 8'h5A);
		// restart while waiting, then a wrong id and a short frame
		put_beat(KIND_START, 16'h00FF, 7'd2, 8'h00);
		put_beat(KIND_START, 16'hFF00, 7'd125, 8'h00);
		put_reply(7'd125, int'(RSP_IDX_ID), 1, 1'b0);
		put_beat(KIND_TIMEOUT, 16'h0000, 7'd0, 8'h00);
		// wrong byte count: data held back, invalid at full length
		put_beat(KIND_START, 16'h5A5A, 7'd1, 8'h00);
		put_reply(7'd1, int'(RSP_IDX_COUNT), 7, 1'b0);

		for (ph = 0; ph < 5; ph++) begin
			drain();
			set_device_id(ph == 0 ? 8'h00 : ph == 1 ? 8'hFF : 8'($urandom));
			if (ph == 2) begin
				// long receiver hold while starts pile up behind it
				holds_asked++;
				flood = 1'b1;
				repeat (6) put_beat(KIND_START, 16'($urandom), 7'($urandom), 8'($urandom));
				flood = 1'b0;
			end
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				run_exchange();
			// close any open exchange before the next setting
			put_beat(KIND_TIMEOUT, 16'($urandom), 7'($urandom), 8'($urandom));
		end
		drain();

		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
